@@ src/stream_search_replace_macros.svh @@
// Assertion macros used by the checker of this block.
`ifndef STREAM_SEARCH_REPLACE_MACROS_SVH
`define STREAM_SEARCH_REPLACE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SSR_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ssr_pkg.sv @@
package ssr_pkg;

    localparam int REG_BYTES = 16;
    localparam int CFG_W     = 64;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 3;

    typedef logic [7:0] byte_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LO  = 3'd0,
        CFG_PATTERN_HI  = 3'd1,
        CFG_PATTERN_LEN = 3'd2,
        CFG_SUBST_LO    = 3'd3,
        CFG_SUBST_HI    = 3'd4,
        CFG_SUBST_LEN   = 3'd5
    } cfg_idx_t;

    // Byte i of a 16-byte string held in two 64-bit words, byte 0 in lo[7:0].
    function automatic byte_t byte_sel(input logic [CFG_W-1:0] lo,
                                       input logic [CFG_W-1:0] hi,
                                       input logic [3:0] i);
        logic [CFG_W-1:0] w;
        w = i[3] ? hi : lo;
        return w[i[2:0]*8 +: 8];
    endfunction

endpackage

@@ src/stream_search_replace.sv @@
// Channel  | Handshake                  | Payload
// ---------+----------------------------+----------------------------------
// text     | text_valid / text_stall    | text_byte, text_last
// result   | result_valid / result_stall| out_byte, out_valid, out_last
// config   | wr_en (no wait)            | wr_index, wr_data
//
// An item that yields at most one result is accepted every cycle unless the
// result side stalls; an item with several results holds the input until the
// result register has sent them all, one per cycle while not stalled. Items
// pass through the input register, then the result register. Reset clears
// the configuration, the window count and all handshake state. A stall on the
// result side backs up into text_stall once the input register is full.
module stream_search_replace #(
    parameter int MAX_PATTERN = 16,
    parameter int MAX_SUBST   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          text_valid,
    output logic                          text_stall,
    input  logic [7:0]                    text_byte,
    input  logic                          text_last,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [7:0]                    out_byte,
    output logic                          out_valid,
    output logic                          out_last,
    input  logic                          wr_en,
    input  logic [ssr_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [ssr_pkg::CFG_W-1:0]     wr_data
);
    import ssr_pkg::*;

    localparam int WIN    = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
    localparam int SUBN   = (MAX_SUBST < REG_BYTES) ? MAX_SUBST : REG_BYTES;
    localparam int BUF    = (WIN + 1 > SUBN) ? WIN + 1 : SUBN;
    localparam int CNT_W  = $clog2(WIN + 1);
    localparam int SLEN_W = $clog2(SUBN + 1);
    localparam int BW     = $clog2(BUF + 1);
    localparam int IW     = $clog2(BUF);

    // Configuration registers.
    logic [CFG_W-1:0] pattern_lo_reg, pattern_hi_reg, subst_lo_reg, subst_hi_reg;
    logic [LEN_W-1:0] pattern_len_reg, subst_len_reg;

    // Input register.
    logic  in_full_reg;
    byte_t in_byte_reg;
    logic  in_last_reg;

    // Match window, index 0 oldest.
    byte_t            win_reg [WIN];
    byte_t            win_next [WIN];
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Result register: a burst of results described by a snapshot and a length.
    logic          buf_busy_reg;
    byte_t         buf_q_reg [WIN+1];
    logic          buf_subst_reg;
    logic          buf_marker_reg;
    logic          buf_last_reg;
    logic [BW-1:0] buf_len_reg;
    logic [IW-1:0] idx_reg;

    logic              take, finishing, load, accept;
    byte_t             q [WIN+1];
    logic [CNT_W-1:0]  plen, cnt_p1;
    logic [SLEN_W-1:0] slen;
    logic              stale, full, match, hit;
    logic [BW-1:0]     emit_len, len_next;
    logic              marker;
    byte_t             q_sel, sub_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_lo_reg  <= '0;
            pattern_hi_reg  <= '0;
            pattern_len_reg <= '0;
            subst_lo_reg    <= '0;
            subst_hi_reg    <= '0;
            subst_len_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_PATTERN_LO:  pattern_lo_reg  <= wr_data;
                CFG_PATTERN_HI:  pattern_hi_reg  <= wr_data;
                CFG_PATTERN_LEN: pattern_len_reg <= wr_data[LEN_W-1:0];
                CFG_SUBST_LO:    subst_lo_reg    <= wr_data;
                CFG_SUBST_HI:    subst_hi_reg    <= wr_data;
                CFG_SUBST_LEN:   subst_len_reg   <= wr_data[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    assign take       = buf_busy_reg && !result_stall;
    assign finishing  = take && (idx_reg == IW'(buf_len_reg - 1'b1));
    assign load       = in_full_reg && (!buf_busy_reg || finishing);
    assign text_stall = in_full_reg && !load;
    assign accept     = text_valid && !text_stall;

    assign plen = (pattern_len_reg > LEN_W'(WIN)) ? CNT_W'(WIN)
                                                  : pattern_len_reg[CNT_W-1:0];
    assign slen = (subst_len_reg > LEN_W'(SUBN)) ? SLEN_W'(SUBN)
                                                 : subst_len_reg[SLEN_W-1:0];

    // The held bytes followed by the new byte; every non-matching outcome
    // emits a prefix of this sequence.
    always_comb
    begin
        for (int i = 0; i <= WIN; i++)
        begin
            q[i] = (CNT_W'(i) < cnt_reg && i < WIN) ? win_reg[i] : in_byte_reg;
        end
    end

    always_comb
    begin
        stale  = cnt_reg >= plen;
        cnt_p1 = cnt_reg + 1'b1;
        full   = !stale && (cnt_p1 == plen);
        match  = 1'b1;
        for (int i = 0; i < WIN; i++)
        begin
            if (CNT_W'(i) < plen && q[i] != byte_sel(pattern_lo_reg, pattern_hi_reg, 4'(i)))
            begin
                match = 1'b0;
            end
        end
        hit = full && match;

        if (stale)
            emit_len = BW'(cnt_reg) + 1'b1;
        else if (hit)
            emit_len = BW'(slen);
        else if (full)
            emit_len = in_last_reg ? BW'(plen) : BW'(1);
        else
            emit_len = in_last_reg ? BW'(cnt_reg) + 1'b1 : '0;

        marker   = in_last_reg && (emit_len == '0);
        len_next = marker ? BW'(1) : emit_len;

        // A mismatch on a full window drops the oldest byte.
        for (int i = 0; i < WIN; i++)
        begin
            win_next[i] = full ? q[i+1] : q[i];
        end
        if (in_last_reg || stale || hit)
            cnt_next = '0;
        else if (full)
            cnt_next = plen - 1'b1;
        else
            cnt_next = cnt_p1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            cnt_reg      <= '0;
            buf_busy_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            if (accept)
                in_full_reg <= 1'b1;
            else if (load)
                in_full_reg <= 1'b0;

            if (load)
            begin
                cnt_reg      <= cnt_next;
                buf_busy_reg <= (len_next != '0);
                idx_reg      <= '0;
            end
            else if (finishing)
            begin
                buf_busy_reg <= 1'b0;
            end
            else if (take)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= text_byte;
            in_last_reg <= text_last;
        end
        if (load)
        begin
            win_reg        <= win_next;
            buf_q_reg      <= q;
            buf_subst_reg  <= hit;
            buf_marker_reg <= marker;
            buf_last_reg   <= in_last_reg;
            buf_len_reg    <= len_next;
        end
    end

    always_comb
    begin
        q_sel   = '0;
        sub_sel = '0;
        for (int i = 0; i <= WIN; i++)
        begin
            if (idx_reg == IW'(i))
                q_sel = buf_q_reg[i];
        end
        for (int i = 0; i < SUBN; i++)
        begin
            if (idx_reg == IW'(i))
                sub_sel = byte_sel(subst_lo_reg, subst_hi_reg, 4'(i));
        end
    end

    assign result_valid = buf_busy_reg;
    assign out_valid    = !buf_marker_reg;
    assign out_byte     = buf_marker_reg ? 8'd0 : (buf_subst_reg ? sub_sel : q_sel);
    assign out_last     = buf_last_reg && (idx_reg == IW'(buf_len_reg - 1'b1));

endmodule

@@ src/ssr_checker.sv @@
`include "stream_search_replace_macros.svh"

module ssr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       text_valid,
    input logic       text_stall,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] out_byte,
    input logic       out_valid,
    input logic       out_last
);
    import ssr_pkg::*;

    // A held result keeps its payload.
    `SSR_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(out_byte) && $stable(out_valid) && $stable(out_last), "stalled result changed")
    // An empty end marker only closes a text.
    `SSR_ASSERT(a_marker_last, result_valid && !out_valid, out_last, "marker without out_last")
    // An empty end marker carries a zero byte.
    `SSR_ASSERT(a_marker_zero, result_valid && !out_valid, out_byte == 8'd0, "marker with nonzero byte")
    // With no result pending the input side never stalls.
    `SSR_ASSERT(a_no_idle_stall, !result_valid, !text_stall, "input stalled with empty output")

endmodule

bind stream_search_replace ssr_checker u_ssr_checker (.*);

@@ tb/tb_top.sv @@
module tb_top;
    import ssr_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 18;
    localparam int MAX_PRINTS    = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } text_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 text_valid;
    logic                 text_stall;
    logic [7:0]           text_byte;
    logic                 text_last;
    logic                 result_valid;
    logic                 result_stall;
    logic [7:0]           out_byte;
    logic                 out_valid;
    logic                 out_last;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0]     wr_data;

    // Shadow copies of the configuration and the match window.
    logic [63:0] pat_lo, pat_hi, sub_lo, sub_hi;
    logic [4:0]  pat_len_r, sub_len_r;
    byte_t       win [16];
    int          win_cnt;

    text_result_t expected_q[$];
    text_result_t step_results[$];

    int  fail_count = 0;
    int  items_sent;
    int  cycle_count = 0;
    bit  idle_on;
    int  hold_requests = 0;

    stream_search_replace dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_byte    (text_byte),
        .text_last    (text_last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .out_valid    (out_valid),
        .out_last     (out_last),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        if (fail_count < MAX_PRINTS)
            $display("MISMATCH %s: got %0h, expected %0h (cycle %0d)",
                     what, got, want, cycle_count);
        fail_count++;
    endtask

    function automatic byte_t cfg_byte(logic [63:0] lo, logic [63:0] hi, int i);
        logic [63:0] w;
        w = (i < 8) ? lo : hi;
        return w[(i % 8) * 8 +: 8];
    endfunction

    function automatic int clamp_len(logic [4:0] v);
        return (v > 5'd16) ? 16 : int'(v);
    endfunction

    function automatic void emit(byte_t v, logic has_byte);
        text_result_t r;
        r.data     = v;
        r.has_byte = has_byte;
        r.last     = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void flush_window();
        int i;
        for (i = 0; i < win_cnt; i++)
            emit(win[i], 1'b1);
        win_cnt = 0;
    endfunction

    // Works out the results that one accepted text byte causes.
    task automatic predict_text(byte_t b, logic last);
        int plen;
        int slen;
        int i;
        bit hit;
        plen = clamp_len(pat_len_r);
        slen = clamp_len(sub_len_r);
        step_results.delete();
        if (win_cnt >= plen)
        begin
            // Either the pattern is empty or it was shortened under a full window.
            flush_window();
            emit(b, 1'b1);
        end
        else
        begin
            win[win_cnt] = b;
            win_cnt++;
            if (win_cnt == plen)
            begin
                hit = 1'b1;
                for (i = 0; i < plen; i++)
                    if (win[i] !== cfg_byte(pat_lo, pat_hi, i))
                        hit = 1'b0;
                if (hit)
                begin
                    for (i = 0; i < slen; i++)
                        emit(cfg_byte(sub_lo, sub_hi, i), 1'b1);
                    win_cnt = 0;
                end
                else
                begin
                    emit(win[0], 1'b1);
                    for (i = 1; i < plen; i++)
                        win[i - 1] = win[i];
                    win_cnt--;
                end
            end
        end
        if (last)
        begin
            flush_window();
            if (step_results.size() == 0)
                emit(8'h00, 1'b0);
            step_results[step_results.size() - 1].last = 1'b1;
        end
        foreach (step_results[j])
            expected_q.push_back(step_results[j]);
    endtask

    always @(posedge clk)
    begin
        text_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_q.size() == 0)
                report_mismatch("result with nothing expected", out_byte, 8'h00);
            else
            begin
                want = expected_q.pop_front();
                if (out_byte !== want.data)
                    report_mismatch("out_byte", out_byte, want.data);
                if (out_valid !== want.has_byte)
                    report_mismatch("out_valid", {7'd0, out_valid}, {7'd0, want.has_byte});
                if (out_last !== want.last)
                    report_mismatch("out_last", {7'd0, out_last}, {7'd0, want.last});
            end
        end
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        int holds_done;
        holds_done   = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                for (int k = 0; k < HOLD_CYCLES; k++)
                begin
                    result_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            result_stall <= idle_on && ($urandom_range(99) < 26);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_text(byte_t b, logic last);
        while (idle_on && $urandom_range(99) < 26)
        begin
            text_valid <= 1'b0;
            @(negedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= b;
        text_last  <= last;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        predict_text(b, last);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            CFG_PATTERN_LO:  pat_lo    = data;
            CFG_PATTERN_HI:  pat_hi    = data;
            CFG_PATTERN_LEN: pat_len_r = data[4:0];
            CFG_SUBST_LO:    sub_lo    = data;
            CFG_SUBST_HI:    sub_hi    = data;
            CFG_SUBST_LEN:   sub_len_r = data[4:0];
            default: ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Stops sending and waits until every expected result has arrived and the
    // block has had time to absorb bytes that produce no result.
    task automatic wait_idle();
        text_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic test_empty_pattern();
        send_text(8'h01, 1'b0);
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b0);
        send_text(8'h80, 1'b1);
        wait_idle();
    endtask

    task automatic test_match_replace();
        write_reg(CFG_PATTERN_LO, 64'h0000_0000_0000_6261);
        write_reg(CFG_PATTERN_HI, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_PATTERN_LEN, 64'd2);
        write_reg(CFG_SUBST_LO, 64'hFFFF_FFFF_FF5A_5958);
        write_reg(CFG_SUBST_HI, 64'h8877_6655_4433_2211);
        write_reg(CFG_SUBST_LEN, 64'd3);
        send_text(8'h61, 1'b0);
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b0);
        send_text(8'h62, 1'b0);
        send_text(8'h61, 1'b1);
        wait_idle();
    endtask

    task automatic test_empty_flush_marker();
        write_reg(CFG_SUBST_LEN, 64'd0);
        // A match on the last byte with an empty replacement leaves only an empty end marker to send.
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b1);
        send_text(8'h61, 1'b1);
        wait_idle();
    endtask

    task automatic test_oversized_lengths();
        write_reg(CFG_PATTERN_LEN, 64'd31);
        write_reg(CFG_SUBST_LEN, 64'd20);
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b0);
        send_text(8'h7F, 1'b1);
        wait_idle();
    endtask

    task automatic test_stale_window();
        write_reg(CFG_PATTERN_LEN, 64'd6);
        write_reg(CFG_SUBST_LEN, 64'd3);
        send_text(8'h71, 1'b0);
        send_text(8'h72, 1'b0);
        send_text(8'h73, 1'b0);
        send_text(8'h74, 1'b0);
        wait_idle();
        // The window now holds more bytes than the shortened pattern.
        write_reg(CFG_PATTERN_LEN, 64'd2);
        send_text(8'h75, 1'b0);
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b1);
        wait_idle();
    endtask

    task automatic set_random_config(int plen, int slen, bit narrow);
        logic [63:0] lo;
        logic [63:0] hi;
        byte_t       v;
        int          i;
        lo = '0;
        hi = '0;
        for (i = 0; i < 16; i++)
        begin
            v = narrow ? byte_t'(8'h61 + $urandom_range(0, 1)) : byte_t'($urandom_range(1, 255));
            if (i < 8)
                lo[i * 8 +: 8] = v;
            else
                hi[(i - 8) * 8 +: 8] = v;
        end
        write_reg(CFG_PATTERN_LO, lo);
        write_reg(CFG_PATTERN_HI, hi);
        write_reg(CFG_PATTERN_LEN, 64'(plen));
        write_reg(CFG_SUBST_LO, {$urandom, $urandom});
        write_reg(CFG_SUBST_HI, {$urandom, $urandom});
        write_reg(CFG_SUBST_LEN, 64'(slen));
    endtask

    // Whole and partial pattern occurrences, single pattern bytes and random bytes.
    task automatic send_random_text();
        byte_t txt[$];
        int    n;
        int    r;
        int    k;
        int    cut;
        int    plen;
        plen = clamp_len(pat_len_r);
        n = $urandom_range(1, 24);
        while (txt.size() < n)
        begin
            r = $urandom_range(99);
            if (plen > 0 && r < 30)
            begin
                for (k = 0; k < plen; k++)
                    txt.push_back(cfg_byte(pat_lo, pat_hi, k));
            end
            else if (plen > 0 && r < 50)
            begin
                cut = $urandom_range(1, plen);
                for (k = 0; k < cut; k++)
                    txt.push_back(cfg_byte(pat_lo, pat_hi, k));
            end
            else if (plen > 0 && r < 75)
                txt.push_back(cfg_byte(pat_lo, pat_hi, $urandom_range(0, plen - 1)));
            else
                txt.push_back(byte_t'($urandom_range(1, 255)));
        end
        for (k = 0; k < txt.size(); k++)
            send_text(txt[k], k == txt.size() - 1);
    endtask

    task automatic test_random_settings();
        int plens[7];
        int slens[7];
        int p;
        int start;
        plens = '{1, 2, 16, 3, 16, 0, 5};
        slens = '{0, 3, 16, 1, 0, 7, 16};
        for (p = 0; p < 7; p++)
        begin
            set_random_config(plens[p], slens[p], p % 2 == 0);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                send_random_text();
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        int k;
        write_reg(CFG_PATTERN_LO, 64'h0000_0000_0000_6261);
        write_reg(CFG_PATTERN_LEN, 64'd2);
        write_reg(CFG_SUBST_LEN, 64'd16);
        idle_on = 1'b0;
        hold_requests++;
        // Every second byte completes a match worth sixteen results.
        for (k = 0; k < 30; k++)
            send_text((k % 2 == 0) ? 8'h61 : 8'h62, k == 29);
        wait_idle();
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        text_valid   = 1'b0;
        text_byte    = 8'h00;
        text_last    = 1'b0;
        wr_en        = 1'b0;
        wr_index     = '0;
        wr_data      = '0;
        pat_lo       = '0;
        pat_hi       = '0;
        sub_lo       = '0;
        sub_hi       = '0;
        pat_len_r    = '0;
        sub_len_r    = '0;
        win_cnt      = 0;
        foreach (win[i])
            win[i] = 8'h00;
        items_sent   = 0;
        idle_on      = 1'b1;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_pattern();
        test_match_replace();
        test_empty_flush_marker();
        test_oversized_lengths();
        test_stale_window();
        test_random_settings();
        test_backpressure();

        wait_idle();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/ssr_pkg.sv
src/stream_search_replace.sv
src/ssr_checker.sv
tb/tb_top.sv
